// File: rtl/vm_alu_execute_with_flags_assert.svh
// Assertion macros for the execute stage.
// Used by the top level only; requires i_clk and i_rst_n in scope.
`ifndef VM_ALU_EXECUTE_WITH_FLAGS_ASSERT_SVH
`define VM_ALU_EXECUTE_WITH_FLAGS_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define VMA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define VMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/vma_pkg.sv
// Package for the execute stage: opcodes, state encoding, control structs.
// No dependencies.
`timescale 1ns / 1ps
package vma_pkg;
    typedef enum logic [4:0] {
        OP_MOV = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
        OP_CMP = 5'd5, OP_SHL = 5'd6, OP_SHR = 5'd7, OP_SAR = 5'd8, OP_AND = 5'd9,
        OP_OR = 5'd10, OP_XOR = 5'd11, OP_SWAP = 5'd12, OP_LDL = 5'd13, OP_LDH = 5'd14,
        OP_NOT = 5'd15, OP_JMP = 5'd16, OP_JZ = 5'd17, OP_JP = 5'd18, OP_JN = 5'd19,
        OP_JNZ = 5'd20, OP_JNP = 5'd21, OP_JNN = 5'd22, OP_STOP = 5'd23
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] HIGH_HALF = 32'hFFFF_0000;
    localparam logic [31:0] LOW_HALF  = 32'h0000_FFFF;

    typedef struct packed {
        logic load;      // capture the item
        logic mul_step;  // register product
        logic div_start; // set up divider
        logic div_step;  // one divider iteration
        logic finish;    // compute result, update flags
    } t_cmd;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_last;
    } t_status;
endpackage

// File: rtl/vma_ctrl.sv
// Controller state machine for the execute stage.
// Depends on vma_pkg.
`timescale 1ns / 1ps
module vma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  vma_pkg::t_status  i_status,
    output vma_pkg::t_cmd     o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);
    import vma_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.is_mul) begin
                    o_cmd.mul_step = 1'b1;
                    n_state = S_MUL;
                end else if (i_status.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_MUL;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: rtl/vma_dp.sv
// Datapath: operand registers, multiplier, radix-2 divider, result logic, flags.
// Depends on vma_pkg.
`timescale 1ns / 1ps
module vma_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vma_pkg::t_cmd                i_cmd,
    input  logic [4:0]                   i_kind,
    input  logic [vma_pkg::DATA_W-1:0]   i_a,
    input  logic [vma_pkg::DATA_W-1:0]   i_b,
    output vma_pkg::t_status             o_status,
    output logic [vma_pkg::DATA_W-1:0]   o_result_a,
    output logic                         o_write_a,
    output logic [vma_pkg::DATA_W-1:0]   o_result_b,
    output logic                         o_write_b,
    output logic [vma_pkg::DATA_W-1:0]   o_remainder,
    output logic                         o_write_remainder,
    output logic                         o_jump_taken,
    output logic                         o_flag_negative,
    output logic                         o_flag_zero,
    output logic                         o_halted,
    output logic                         o_divide_fault
);
    import vma_pkg::*;

    logic [4:0]        r_kind;
    logic [DATA_W-1:0] r_a, r_b, r_prod;
    logic [DATA_W-1:0] r_quo, r_rem, r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg_q, r_neg_r;
    logic              r_n, r_z, r_stop;
    logic [DATA_W-1:0] r_ra, r_rb, r_rr;
    logic              r_wa, r_wb, r_wr, r_jmp, r_fault;

    logic              live;
    logic [DATA_W:0]   trial_rem;
    logic [DATA_W:0]   trial_sub;
    logic [DATA_W-1:0] ua, ub;

    assign live = !r_stop;
    assign o_status.is_mul = live && (r_kind == OP_MUL);
    assign o_status.is_div = live && (r_kind == OP_DIV) && (r_b != '0);
    assign o_status.div_last = (r_cnt == '0);

    assign ua = r_a[DATA_W-1] ? (~r_a + 1'b1) : r_a;
    assign ub = r_b[DATA_W-1] ? (~r_b + 1'b1) : r_b;
    assign trial_rem = {r_rem, r_quo[DATA_W-1]};
    assign trial_sub = trial_rem - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_a <= i_a;
            r_b <= i_b;
        end
        if (i_cmd.mul_step) r_prod <= r_a * r_b;
        if (i_cmd.div_start) begin
            r_quo <= ua;
            r_rem <= '0;
            r_div <= ub;
            r_cnt <= CNT_W'(DATA_W - 1);
            r_neg_q <= r_a[DATA_W-1] ^ r_b[DATA_W-1];
            r_neg_r <= r_a[DATA_W-1];
        end else if (i_cmd.div_step) begin
            // shift-subtract restoring step
            if (!trial_sub[DATA_W]) begin
                r_rem <= trial_sub[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= trial_rem[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    logic [DATA_W-1:0] val, n_ra, n_rb, n_rr;
    logic              n_wa, n_wb, n_wr, n_jmp, n_fault, n_stop, setf, cond;

    always_comb begin
        val = '0; n_ra = '0; n_rb = '0; n_rr = '0;
        n_wa = 1'b0; n_wb = 1'b0; n_wr = 1'b0; n_jmp = 1'b0; n_fault = 1'b0;
        n_stop = r_stop; setf = 1'b0; cond = 1'b0;
        if (live) begin
            case (r_kind)
                OP_MOV: begin val = r_b; n_wa = 1'b1; end
                OP_ADD: begin val = r_a + r_b; n_wa = 1'b1; setf = 1'b1; end
                OP_SUB: begin val = r_a - r_b; n_wa = 1'b1; setf = 1'b1; end
                OP_MUL: begin val = r_prod; n_wa = 1'b1; setf = 1'b1; end
                OP_DIV: begin
                    if (r_b == '0) begin
                        n_fault = 1'b1;
                        n_stop = 1'b1;
                    end else begin
                        val = r_neg_q ? (~r_quo + 1'b1) : r_quo;
                        n_rr = r_neg_r ? (~r_rem + 1'b1) : r_rem;
                        n_wa = 1'b1; n_wr = 1'b1; setf = 1'b1;
                    end
                end
                OP_CMP: begin val = r_a - r_b; setf = 1'b1; end
                OP_SHL: begin
                    val = (r_b[DATA_W-1:5] != '0) ? '0 : (r_a << r_b[4:0]);
                    n_wa = 1'b1; setf = 1'b1;
                end
                OP_SHR: begin
                    val = (r_b[DATA_W-1:5] != '0) ? '0 : (r_a >> r_b[4:0]);
                    n_wa = 1'b1; setf = 1'b1;
                end
                OP_SAR: begin
                    val = (r_b[DATA_W-1:5] != '0) ? {DATA_W{r_a[DATA_W-1]}}
                                                   : DATA_W'($signed(r_a) >>> r_b[4:0]);
                    n_wa = 1'b1; setf = 1'b1;
                end
                OP_AND: begin val = r_a & r_b; n_wa = 1'b1; setf = 1'b1; end
                OP_OR:  begin val = r_a | r_b; n_wa = 1'b1; setf = 1'b1; end
                OP_XOR: begin val = r_a ^ r_b; n_wa = 1'b1; setf = 1'b1; end
                OP_SWAP: begin val = r_b; n_wa = 1'b1; n_rb = r_a; n_wb = 1'b1; end
                OP_LDL: begin val = (r_a & HIGH_HALF) | (r_b & LOW_HALF); n_wa = 1'b1; end
                OP_LDH: begin val = {r_b[15:0], r_a[15:0]}; n_wa = 1'b1; end
                OP_NOT: begin val = ~r_a; n_wa = 1'b1; setf = 1'b1; end
                OP_JMP: cond = 1'b1;
                OP_JZ:  cond = r_z;
                OP_JP:  cond = !r_n && !r_z;
                OP_JN:  cond = r_n;
                OP_JNZ: cond = !r_z;
                OP_JNP: cond = r_n || r_z;
                OP_JNN: cond = !r_n;
                OP_STOP: begin n_ra = ALL_ONES; n_jmp = 1'b1; n_stop = 1'b1; end
                default: ;
            endcase
            if (cond) begin
                n_ra = r_a;
                n_jmp = 1'b1;
            end
            if (n_wa) n_ra = val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 1'b0;
            r_z <= 1'b0;
            r_stop <= 1'b0;
        end else if (i_cmd.finish) begin
            r_stop <= n_stop;
            if (setf) begin
                r_n <= val[DATA_W-1];
                r_z <= (val == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_ra <= n_ra; r_rb <= n_rb; r_rr <= n_rr;
            r_wa <= n_wa; r_wb <= n_wb; r_wr <= n_wr;
            r_jmp <= n_jmp; r_fault <= n_fault;
        end
    end

    assign o_result_a = r_ra;
    assign o_write_a = r_wa;
    assign o_result_b = r_rb;
    assign o_write_b = r_wb;
    assign o_remainder = r_rr;
    assign o_write_remainder = r_wr;
    assign o_jump_taken = r_jmp;
    assign o_flag_negative = r_n;
    assign o_flag_zero = r_z;
    assign o_halted = r_stop;
    assign o_divide_fault = r_fault;
endmodule

// File: rtl/vm_alu_execute_with_flags.sv
// Execute stage of a 32-bit machine with N/Z flags and halt.
// One item in flight. IDLE captures the item; FIN registers the result, or the MUL product
// (then S_MUL), or starts the 32-step divider (S_DIV, then S_MUL); S_OUT offers it.
// The result register holds until taken; the next item is accepted after that.
// Synchronous active-low reset clears flags, halt bit and controller to idle.
// Depends on vma_pkg, vma_ctrl, vma_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "vm_alu_execute_with_flags_assert.svh"
module vm_alu_execute_with_flags (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [63:0]   s_axis_tdata,  // operand_a[31:0], operand_b[63:32]
    input  logic [4:0]    s_axis_tuser,  // kind[4:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata   // result_a, write_a, result_b, write_b,
                                          // remainder, write_remainder, jump_taken,
                                          // flag_negative, flag_zero, halted,
                                          // divide_fault
);
    import vma_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic [31:0] ra, rb, rr;
    logic wa, wb, wr, jmp, fn, fz, hlt, flt;

    vma_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(status), .o_cmd(cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    vma_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_kind(s_axis_tuser), .i_a(s_axis_tdata[31:0]), .i_b(s_axis_tdata[63:32]),
        .o_status(status),
        .o_result_a(ra), .o_write_a(wa), .o_result_b(rb), .o_write_b(wb),
        .o_remainder(rr), .o_write_remainder(wr), .o_jump_taken(jmp),
        .o_flag_negative(fn), .o_flag_zero(fz), .o_halted(hlt), .o_divide_fault(flt)
    );

    assign m_axis_tdata = {flt, hlt, fz, fn, jmp, wr, rr, wb, rb, wa, ra};

    `VMA_ASSERT_IMP(a_one_side, s_axis_tready, !m_axis_tvalid)
    `VMA_ASSERT_IMP(a_fault_halts, m_axis_tvalid && m_axis_tdata[103], m_axis_tdata[102])
    `VMA_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
